// ===== rtl/core/acia_pkg.sv =====
// ----------------------------------------------------------------------------
// acia_pkg
// Types, codes and decode functions shared by the serial register file.
// ----------------------------------------------------------------------------
package acia_pkg;

    // Request commands.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    // Register offsets within the card I/O space.
    localparam logic [3:0] ADDR_SWITCH1 = 4'h1;
    localparam logic [3:0] ADDR_SWITCH2 = 4'h2;
    localparam logic [3:0] ADDR_DATA    = 4'h8;
    localparam logic [3:0] ADDR_STATUS  = 4'h9;
    localparam logic [3:0] ADDR_COMMAND = 4'hA;
    localparam logic [3:0] ADDR_CONTROL = 4'hB;

    // Switch register indexes on the configuration port.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_BAUD_INDEX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRMWARE_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_STOP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEVEN_BITS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEFEED      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERRUPTS    = 3'd6;

    // Parity codes.
    localparam logic [2:0] PAR_NONE = 3'd0;
    localparam logic [2:0] PAR_ODD  = 3'd1;
    localparam logic [2:0] PAR_EVEN = 3'd2;

    // Stop bit codes.
    localparam logic [1:0] STOP_ONE      = 2'd0;
    localparam logic [1:0] STOP_ONE_HALF = 2'd1;
    localparam logic [1:0] STOP_TWO      = 2'd2;

    localparam logic [3:0] SIZE_FIVE  = 4'd5;
    localparam logic [3:0] SIZE_SEVEN = 4'd7;
    localparam logic [3:0] SIZE_EIGHT = 4'd8;

    typedef struct packed {
        logic [3:0] baud_index;
        logic [3:0] firmware_mode;
        logic       two_stop;
        logic       seven_bits;
        logic [1:0] parity;
        logic       linefeed;
        logic       interrupts;
    } t_switches;

    localparam t_switches SWITCHES_RESET = '{
        baud_index:    4'hF,
        firmware_mode: 4'h0,
        two_stop:      1'b0,
        seven_bits:    1'b0,
        parity:        2'd0,
        linefeed:      1'b1,
        interrupts:    1'b0
    };

    // Line setup derived from the control and command registers.
    typedef struct packed {
        logic [7:0] control;
        logic [2:0] parity;
        logic [3:0] size;
        logic [1:0] stop;
        logic [2:0] baud;
    } t_line;

    // A switch change reloads the line setup.
    typedef struct packed {
        logic  load;
        t_line line;
    } t_sw_update;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_data;
        logic       irq;
        logic [2:0] parity;
        logic [3:0] size;
        logic [1:0] stop;
        logic [2:0] baud;
    } t_result;

    function automatic logic [2:0] baud_decode(input logic [3:0] idx);
        logic [2:0] code;
        case (idx)
            4'd6:          code = 3'd1;
            4'd7:          code = 3'd2;
            4'd8:          code = 3'd3;
            4'd9, 4'd10:   code = 3'd4;
            4'd11, 4'd12:  code = 3'd5;
            4'd13, 4'd14:  code = 3'd6;
            4'd15:         code = 3'd7;
            default:       code = 3'd0;
        endcase
        return code;
    endfunction

    // Parity switch value three means no parity.
    function automatic logic [2:0] switch_parity(input logic [1:0] p);
        return (p == 2'd1 || p == 2'd2) ? {1'b0, p} : PAR_NONE;
    endfunction

    function automatic t_line derive_line(input t_switches sw);
        t_line      ln;
        logic       stopbit;
        logic [3:0] short_by;
        ln.parity = switch_parity(sw.parity);
        ln.size   = sw.seven_bits ? SIZE_SEVEN : SIZE_EIGHT;
        ln.stop   = sw.two_stop ? STOP_TWO : STOP_ONE;
        ln.baud   = baud_decode(sw.baud_index);
        stopbit   = (ln.size == SIZE_EIGHT && ln.parity != PAR_NONE) || ln.stop != STOP_ONE;
        short_by  = SIZE_EIGHT - ln.size;
        ln.control = {stopbit, short_by[1:0], 1'b1, sw.baud_index};
        return ln;
    endfunction

    localparam t_line LINE_RESET = derive_line(SWITCHES_RESET);

endpackage

// ===== rtl/core/acia_switches.sv =====
// ----------------------------------------------------------------------------
// acia_switches
// Switch setting registers and the line setup that a switch change loads.
// ----------------------------------------------------------------------------
module acia_switches (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [acia_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acia_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output acia_pkg::t_switches             o_sw,
    output acia_pkg::t_sw_update            o_update
);

    acia_pkg::t_switches r_sw;
    acia_pkg::t_switches n_sw;
    logic                known;

    always_comb begin
        n_sw  = r_sw;
        known = 1'b1;
        unique case (i_cfg_index)
            acia_pkg::CFG_BAUD_INDEX:    n_sw.baud_index    = i_cfg_wdata;
            acia_pkg::CFG_FIRMWARE_MODE: n_sw.firmware_mode = i_cfg_wdata;
            acia_pkg::CFG_TWO_STOP:      n_sw.two_stop      = i_cfg_wdata[0];
            acia_pkg::CFG_SEVEN_BITS:    n_sw.seven_bits    = i_cfg_wdata[0];
            acia_pkg::CFG_PARITY:        n_sw.parity        = i_cfg_wdata[1:0];
            acia_pkg::CFG_LINEFEED:      n_sw.linefeed      = i_cfg_wdata[0];
            acia_pkg::CFG_INTERRUPTS:    n_sw.interrupts    = i_cfg_wdata[0];
            default:                     known              = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= acia_pkg::SWITCHES_RESET;
        end else if (i_cfg_we && known) begin
            r_sw <= n_sw;
        end
    end

    assign o_sw            = r_sw;
    assign o_update.load   = i_cfg_we && known;
    assign o_update.line   = acia_pkg::derive_line(n_sw);

endmodule

// ===== rtl/core/acia_regs.sv =====
// ----------------------------------------------------------------------------
// acia_regs
// Card register state and the decode of one bus or line request.
// ----------------------------------------------------------------------------
module acia_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [1:0]           i_cmd,
    input  logic [3:0]           i_reg_addr,
    input  logic [7:0]           i_wdata,
    input  logic [7:0]           i_rx_byte,
    input  acia_pkg::t_switches  i_sw,
    input  acia_pkg::t_sw_update i_update,
    output acia_pkg::t_result    o_result
);

    logic [7:0] r_command, n_command;
    acia_pkg::t_line r_line, n_line;
    logic r_tx_en, n_tx_en;
    logic r_rx_en, n_rx_en;
    logic r_tx_written, n_tx_written;
    logic r_rx_full, n_rx_full;
    logic [7:0] r_holding, n_holding;
    logic r_irq, n_irq;

    logic [7:0] rdata;
    logic       txv;
    logic [7:0] txd;
    logic [7:0] status;
    logic [7:0] switch2;
    logic [2:0] sw_par;
    logic [3:0] new_size;

    always_comb begin
        sw_par  = acia_pkg::switch_parity(i_sw.parity);
        switch2 = {i_sw.two_stop, 1'b0, i_sw.seven_bits, 1'b0,
                   sw_par == acia_pkg::PAR_EVEN, sw_par != acia_pkg::PAR_NONE,
                   i_sw.linefeed, i_sw.interrupts};
        status  = {(r_tx_en && r_tx_written) || (r_rx_en && r_rx_full), 2'b00, 1'b1,
                   r_rx_full, 3'b000};
        new_size = acia_pkg::SIZE_EIGHT - {2'b00, i_wdata[6:5]};

        n_command    = r_command;
        n_line       = r_line;
        n_tx_en      = r_tx_en;
        n_rx_en      = r_rx_en;
        n_tx_written = r_tx_written;
        n_rx_full    = r_rx_full;
        n_holding    = r_holding;
        n_irq        = r_irq;
        rdata        = 8'h00;
        txv          = 1'b0;
        txd          = 8'h00;

        case (i_cmd)
            acia_pkg::CMD_READ: begin
                unique case (i_reg_addr)
                    acia_pkg::ADDR_SWITCH1: rdata = {i_sw.baud_index, i_sw.firmware_mode};
                    acia_pkg::ADDR_SWITCH2: rdata = switch2;
                    acia_pkg::ADDR_DATA: begin
                        if (r_rx_full) begin
                            rdata     = r_holding;
                            n_rx_full = 1'b0;
                        end
                    end
                    acia_pkg::ADDR_STATUS: begin
                        rdata        = status;
                        n_tx_written = 1'b0;
                        n_irq        = 1'b0;
                    end
                    acia_pkg::ADDR_COMMAND: rdata = r_command;
                    acia_pkg::ADDR_CONTROL: rdata = r_line.control;
                    default: ;
                endcase
            end
            acia_pkg::CMD_WRITE: begin
                unique case (i_reg_addr)
                    acia_pkg::ADDR_DATA: begin
                        txv          = 1'b1;
                        txd          = i_wdata;
                        n_tx_written = 1'b1;
                    end
                    acia_pkg::ADDR_STATUS: begin
                        n_tx_written = 1'b0;
                        n_irq        = 1'b0;
                    end
                    acia_pkg::ADDR_COMMAND: begin
                        // Writing the value already held leaves the decode alone.
                        if (i_wdata != r_command) begin
                            n_command     = i_wdata;
                            n_line.parity = i_wdata[5] ? ({1'b0, i_wdata[7:6]} + 3'd1)
                                                       : acia_pkg::PAR_NONE;
                            n_tx_en       = (i_wdata[3:2] == 2'b01);
                            n_rx_en       = !i_wdata[1];
                        end
                    end
                    acia_pkg::ADDR_CONTROL: begin
                        if (i_wdata != r_line.control) begin
                            n_line.control = i_wdata;
                            n_line.baud    = acia_pkg::baud_decode(i_wdata[3:0]);
                            n_line.size    = new_size;
                            // The stop bit setting depends on size and current parity.
                            if (!i_wdata[7]) begin
                                n_line.stop = acia_pkg::STOP_ONE;
                            end else if (new_size == acia_pkg::SIZE_EIGHT
                                         && r_line.parity != acia_pkg::PAR_NONE) begin
                                n_line.stop = acia_pkg::STOP_ONE;
                            end else if (new_size == acia_pkg::SIZE_FIVE
                                         && r_line.parity == acia_pkg::PAR_NONE) begin
                                n_line.stop = acia_pkg::STOP_ONE_HALF;
                            end else begin
                                n_line.stop = acia_pkg::STOP_TWO;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            acia_pkg::CMD_RX: begin
                n_holding = i_rx_byte;
                n_rx_full = 1'b1;
                if (r_rx_en) begin
                    n_irq = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_command    <= 8'h00;
            r_line       <= acia_pkg::LINE_RESET;
            r_tx_en      <= 1'b0;
            r_rx_en      <= 1'b0;
            r_tx_written <= 1'b0;
            r_rx_full    <= 1'b0;
            r_holding    <= 8'h00;
            r_irq        <= 1'b0;
        end else if (i_update.load) begin
            r_line <= i_update.line;
        end else if (i_fire) begin
            r_command    <= n_command;
            r_line       <= n_line;
            r_tx_en      <= n_tx_en;
            r_rx_en      <= n_rx_en;
            r_tx_written <= n_tx_written;
            r_rx_full    <= n_rx_full;
            r_holding    <= n_holding;
            r_irq        <= n_irq;
        end
    end

    assign o_result.rdata    = rdata;
    assign o_result.tx_valid = txv;
    assign o_result.tx_data  = txd;
    assign o_result.irq      = n_irq;
    assign o_result.parity   = n_line.parity;
    assign o_result.size     = n_line.size;
    assign o_result.stop     = n_line.stop;
    assign o_result.baud     = n_line.baud;

endmodule

// ===== rtl/core/acia_serial_register_file.sv =====
// ----------------------------------------------------------------------------
// acia_serial_register_file
// Register file of a 6551-style serial card with switch readbacks.
// ----------------------------------------------------------------------------
// Each request (bus read, bus write or received line byte) is captured in an
// input register, decoded combinationally against the card registers and
// placed in a result register, so the block takes one request per clock
// while results are taken. The input register can still take one request
// while a result waits to be taken; only a full input register behind a
// stalled result holds the input off. The user must write switch settings
// through the configuration port only while no request is in flight; the
// block does not enforce this. A switch write reloads the line setup at once.
module acia_serial_register_file (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [acia_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [acia_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [3:0]                      i_reg_addr,
    input  logic [7:0]                      i_wdata,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_rdata,
    output logic                            o_tx_valid,
    output logic [7:0]                      o_tx_data,
    output logic                            o_irq,
    output logic [2:0]                      o_parity_mode,
    output logic [3:0]                      o_data_bits,
    output logic [1:0]                      o_stop_mode,
    output logic [2:0]                      o_baud_code
);

    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [3:0] r_reg_addr;
    logic [7:0] r_wdata;
    logic [7:0] r_rx_byte;
    logic       r_out_valid;
    acia_pkg::t_result r_result;

    acia_pkg::t_switches  sw;
    acia_pkg::t_sw_update update;
    acia_pkg::t_result    result;
    logic                 advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    acia_switches u_switches (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sw        (sw),
        .o_update    (update)
    );

    acia_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_cmd      (r_cmd),
        .i_reg_addr (r_reg_addr),
        .i_wdata    (r_wdata),
        .i_rx_byte  (r_rx_byte),
        .i_sw       (sw),
        .i_update   (update),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd      <= i_cmd;
            r_reg_addr <= i_reg_addr;
            r_wdata    <= i_wdata;
            r_rx_byte  <= i_rx_byte;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_rdata       = r_result.rdata;
    assign o_tx_valid    = r_result.tx_valid;
    assign o_tx_data     = r_result.tx_data;
    assign o_irq         = r_result.irq;
    assign o_parity_mode = r_result.parity;
    assign o_data_bits   = r_result.size;
    assign o_stop_mode   = r_result.stop;
    assign o_baud_code   = r_result.baud;

endmodule
